@@ src/lmss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared types, constants and helpers for the LED matrix shadow serializer.
// ----------------------------------------------------------------------------
package lmss_pkg;

  localparam int unsigned ROWS_DEF   = 8;
  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS);

  typedef enum logic [1:0] {
    REQ_RAW  = 2'd0,
    REQ_PIXW = 2'd1,
    REQ_PIXR = 2'd2,
    REQ_PAT  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SHIFT = 2'd1,
    ST_READ  = 2'd2
  } lmss_state_e;

  // Logical row position 0 is wired to bit 7, the others one bit lower.
  function automatic logic [7:0] pixel_mask(input logic [2:0] y);
    logic [2:0] b;
    b = (y == 3'd0) ? 3'd7 : (y - 3'd1);
    return 8'd1 << b;
  endfunction

  function automatic logic [7:0] rotate_right1(input logic [7:0] b);
    return {b[0], b[7:1]};
  endfunction

endpackage

@@ src/lmss_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmss_req_if / lmss_rsp_if
// Valid/ready channels for requests and per-bit results.
// ----------------------------------------------------------------------------
interface lmss_req_if import lmss_pkg::*; ();
  logic       valid;
  logic       ready;
  req_type_e  req_type;
  logic [7:0] reg_addr;
  logic [7:0] reg_value;
  logic [2:0] column;
  logic [2:0] row_bit;
  logic       pixel_on;

  modport source (output valid, req_type, reg_addr, reg_value, column, row_bit, pixel_on,
                  input ready);
  modport sink   (input valid, req_type, reg_addr, reg_value, column, row_bit, pixel_on,
                  output ready);
endinterface

interface lmss_rsp_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic frame_done;
  logic read_valid;
  logic pixel_value;
  logic last;

  modport source (output valid, serial_bit, frame_done, read_valid, pixel_value, last,
                  input ready);
  modport sink   (input valid, serial_bit, frame_done, read_valid, pixel_value, last,
                  output ready);
endinterface

@@ src/led_matrix_shadow_serializer.sv @@
`timescale 1ns / 1ps
// The first result shows in the cycle after the request transfer.
// A write sends 16 results, one frame bit per cycle while the receiver is ready,
// from a 16-bit shift register; a pixel read gives one result.
// The next request is taken on the edge that transfers the last result.
// Reset clears the control state and all shadow rows to zero.
// ----------------------------------------------------------------------------
// led_matrix_shadow_serializer
// Serializes register frames MSB first and keeps a shadow of the row registers.
// ----------------------------------------------------------------------------
module led_matrix_shadow_serializer import lmss_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lmss_req_if.sink   req_i,
  lmss_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (ROWS > 1) ? $clog2(ROWS) : 1;

  lmss_state_e state_q, state_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  pix_q, pix_d;
  logic [7:0]            shadow_q [ROWS];

  logic       in_fire, out_fire, out_last;
  logic       col_in_range, addr_in_range, is_write;
  logic [7:0] row_old, row_new, addr_b, val_b;
  logic [IdxW-1:0] wr_idx;

  assign in_fire  = req_i.valid && req_i.ready;
  assign out_fire = rsp_o.valid && rsp_o.ready;
  assign out_last = (state_q == ST_READ) ||
                    ((state_q == ST_SHIFT) && (cnt_q == CNT_W'(FRAME_BITS - 1)));

  assign req_i.ready = (state_q == ST_IDLE) || (out_fire && out_last);

  // Request decode: frame address and value byte
  assign col_in_range = {1'b0, req_i.column} < 4'(ROWS);
  assign row_old = col_in_range ? shadow_q[req_i.column[IdxW-1:0]] : 8'd0;
  assign row_new = req_i.pixel_on ? (row_old | pixel_mask(req_i.row_bit))
                                  : (row_old & ~pixel_mask(req_i.row_bit));

  always_comb begin
    addr_b = {5'd0, req_i.column} + 8'd1;
    val_b  = row_new;
    unique case (req_i.req_type)
      REQ_RAW: begin
        addr_b = req_i.reg_addr;
        val_b  = req_i.reg_value;
      end
      REQ_PIXW: val_b = row_new;
      REQ_PIXR: val_b = 8'd0;
      REQ_PAT:  val_b = rotate_right1(req_i.reg_value);
      default:  val_b = 8'd0;
    endcase
  end

  assign is_write      = req_i.req_type != REQ_PIXR;
  assign addr_in_range = (addr_b >= 8'd1) && (addr_b <= 8'(ROWS));
  assign wr_idx        = IdxW'(addr_b - 8'd1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = is_write ? ST_SHIFT : ST_READ;
      end
      ST_SHIFT, ST_READ: begin
        if (in_fire) begin
          state_d = is_write ? ST_SHIFT : ST_READ;
        end else if (out_fire && out_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    pix_d   = pix_q;
    if (in_fire) begin
      shift_d = {addr_b, val_b};
      cnt_d   = '0;
      pix_d   = |(row_old & pixel_mask(req_i.row_bit));
    end else if (out_fire && (state_q == ST_SHIFT)) begin
      // advance one bit, MSB first
      shift_d = {shift_q[FRAME_BITS-2:0], 1'b0};
      cnt_d   = cnt_q + CNT_W'(1);
    end
  end

  // Outputs
  always_comb begin
    rsp_o.valid       = state_q != ST_IDLE;
    rsp_o.serial_bit  = (state_q == ST_SHIFT) && shift_q[FRAME_BITS-1];
    rsp_o.frame_done  = (state_q == ST_SHIFT) && out_last;
    rsp_o.read_valid  = state_q == ST_READ;
    rsp_o.pixel_value = (state_q == ST_READ) && pix_q;
    rsp_o.last        = out_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    pix_q   <= pix_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) shadow_q[i] <= 8'd0;
    end else if (in_fire && is_write && addr_in_range) begin
      shadow_q[wr_idx] <= val_b;
    end
  end

endmodule

@@ src/lmss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmss_checker
// Port-level checks on the serializer, bound to the top level.
// ----------------------------------------------------------------------------
module lmss_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic serial_bit_i,
  input logic frame_done_i,
  input logic read_valid_i,
  input logic last_i
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // A read answer is a single result with no frame bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && read_valid_i |-> last_i && !frame_done_i && !serial_bit_i)
    else $error("malformed read answer");

  // Frame end and request end coincide on writes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !read_valid_i |-> frame_done_i == last_i)
    else $error("frame_done and last disagree");

  // A new request only enters when the previous one is fully delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |-> !rsp_valid_i || (rsp_ready_i && last_i))
    else $error("request taken mid-frame");

  // A frame keeps going until its last bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ready_i && !last_i |=> rsp_valid_i && !read_valid_i)
    else $error("frame cut short");

endmodule

bind led_matrix_shadow_serializer lmss_checker u_lmss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .serial_bit_i (rsp_o.serial_bit),
  .frame_done_i (rsp_o.frame_done),
  .read_valid_i (rsp_o.read_valid),
  .last_i       (rsp_o.last)
);

@@ verif/led_matrix_shadow_serializer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_shadow_serializer_tb
// Sends raw, pixel and row pattern requests through the request channel and
// checks every serial bit and pixel read answer against a local shadow of the
// eight row registers. The sender runs in bursts with gaps; the receiver
// stalls in changing patterns.
// ----------------------------------------------------------------------------
module led_matrix_shadow_serializer_tb;
  import lmss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RAND_REQS   = 406;
  localparam int unsigned DRAIN_WAIT  = 20;

  typedef struct {
    req_type_e  kind;
    logic [7:0] reg_addr;
    logic [7:0] reg_value;
    logic [2:0] column;
    logic [2:0] row_bit;
    logic       pixel_on;
    logic       drain;     // hold this request until the link is quiet
  } lmss_req_t;

  typedef struct {
    logic serial_bit;
    logic frame_done;
    logic read_valid;
    logic pixel_value;
    logic last;
  } link_bit_t;

  logic clk_i;
  logic rst_ni;

  lmss_req_if req_if ();
  lmss_rsp_if rsp_if ();

  led_matrix_shadow_serializer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  lmss_req_t   pend_q[$];
  link_bit_t   link_bit_q[$];
  logic [7:0]  row_copy [8];

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned bits_checked;
  int unsigned lit_reads;
  int unsigned kind_cnt [4];

  logic        req_took;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned mode_left;
  int unsigned ready_mode;
  logic [12:0] stall_pat;

  always #1 clk_i = ~clk_i;

  // Update the shadow copy and queue the link bits one request produces.
  task automatic serialize_request(input lmss_req_t r);
    logic [7:0]  addr;
    logic [7:0]  val;
    logic [7:0]  row;
    logic [2:0]  bit_pos;
    logic [15:0] word;
    link_bit_t   b;
    bit_pos = (r.row_bit == 3'd0) ? 3'd7 : r.row_bit - 3'd1;
    addr    = {5'd0, r.column} + 8'd1;
    val     = r.reg_value;
    case (r.kind)
      REQ_RAW: begin
        addr = r.reg_addr;
      end
      REQ_PIXW: begin
        row          = row_copy[r.column];
        row[bit_pos] = r.pixel_on;
        val          = row;
      end
      REQ_PIXR: begin
        b.serial_bit  = 1'b0;
        b.frame_done  = 1'b0;
        b.read_valid  = 1'b1;
        b.pixel_value = row_copy[r.column][bit_pos];
        b.last        = 1'b1;
        if (b.pixel_value) lit_reads++;
        link_bit_q.push_back(b);
        return;
      end
      default: begin
        val = {r.reg_value[0], r.reg_value[7:1]};
      end
    endcase
    if (addr >= 8'd1 && addr <= 8'd8) row_copy[3'(addr - 8'd1)] = val;
    word = {addr, val};
    for (int k = 0; k < 16; k++) begin
      b.serial_bit  = word[15 - k];
      b.frame_done  = (k == 15);
      b.read_valid  = 1'b0;
      b.pixel_value = 1'b0;
      b.last        = (k == 15);
      link_bit_q.push_back(b);
    end
  endtask

  task automatic add_req(input req_type_e kind, input logic [7:0] addr,
                         input logic [7:0] val, input logic [2:0] col,
                         input logic [2:0] rb, input logic on, input logic drain);
    lmss_req_t r;
    r.kind      = kind;
    r.reg_addr  = addr;
    r.reg_value = val;
    r.column    = col;
    r.row_bit   = rb;
    r.pixel_on  = on;
    r.drain     = drain;
    pend_q.push_back(r);
  endtask

  // Request side: present the front of the queue, bursts separated by gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!(req_if.valid && !req_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pend_q.size() > 0 && !(pend_q[0].drain && link_bit_q.size() != 0)) begin
        req_if.valid     <= 1'b1;
        req_if.req_type  <= pend_q[0].kind;
        req_if.reg_addr  <= pend_q[0].reg_addr;
        req_if.reg_value <= pend_q[0].reg_value;
        req_if.column    <= pend_q[0].column;
        req_if.row_bit   <= pend_q[0].row_bit;
        req_if.pixel_on  <= pend_q[0].pixel_on;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result side: switch between always ready, random stalls and a fixed pattern.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(16, 120);
    end
    mode_left--;
    stall_pat = {stall_pat[0], stall_pat[12:1]};
    case (ready_mode)
      0:       rsp_if.ready <= 1'b1;
      1:       rsp_if.ready <= ($urandom_range(0, 9) < 6);
      default: rsp_if.ready <= stall_pat[0];
    endcase
  end

  // Transfers on both channels.
  always @(posedge clk_i) begin
    lmss_req_t r;
    link_bit_t e;
    req_took = 1'b0;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        req_took    = 1'b1;
        r           = pend_q.pop_front();
        r.kind      = req_if.req_type;
        r.reg_addr  = req_if.reg_addr;
        r.reg_value = req_if.reg_value;
        r.column    = req_if.column;
        r.row_bit   = req_if.row_bit;
        r.pixel_on  = req_if.pixel_on;
        kind_cnt[r.kind]++;
        serialize_request(r);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (link_bit_q.size() == 0) begin
          $error("unexpected result: serial_bit=%0b last=%0b read_valid=%0b",
                 rsp_if.serial_bit, rsp_if.last, rsp_if.read_valid);
          err_cnt++;
        end else begin
          e = link_bit_q.pop_front();
          bits_checked++;
          if (rsp_if.serial_bit !== e.serial_bit) begin
            $error("serial_bit: expected %0b, got %0b", e.serial_bit, rsp_if.serial_bit);
            err_cnt++;
          end
          if (rsp_if.frame_done !== e.frame_done) begin
            $error("frame_done: expected %0b, got %0b", e.frame_done, rsp_if.frame_done);
            err_cnt++;
          end
          if (rsp_if.read_valid !== e.read_valid) begin
            $error("read_valid: expected %0b, got %0b", e.read_valid, rsp_if.read_valid);
            err_cnt++;
          end
          if (rsp_if.pixel_value !== e.pixel_value) begin
            $error("pixel_value: expected %0b, got %0b", e.pixel_value, rsp_if.pixel_value);
            err_cnt++;
          end
          if (rsp_if.last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, rsp_if.last);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("led_matrix_shadow_serializer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    logic [7:0]  addr;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_RAW;
    req_if.reg_addr  = 8'd0;
    req_if.reg_value = 8'd0;
    req_if.column    = 3'd0;
    req_if.row_bit   = 3'd0;
    req_if.pixel_on  = 1'b0;
    rsp_if.ready     = 1'b0;
    err_cnt          = 0;
    cycle_cnt        = 0;
    bits_checked     = 0;
    lit_reads        = 0;
    kind_cnt         = '{default: 0};
    req_took         = 1'b0;
    burst_left       = 8;
    gap_left         = 0;
    mode_left        = 0;
    ready_mode       = 0;
    stall_pat        = 13'b1011011101101;
    for (int i = 0; i < 8; i++) row_copy[i] = 8'd0;

    // Directed: reset shadow, addresses at and past the shadow edges,
    // pixel bit remap at both ends, rotate wrap-around from bit 0 to bit 7.
    add_req(REQ_PIXR, 8'h00, 8'h00, 3'd3, 3'd0, 1'b0, 1'b0);
    add_req(REQ_RAW,  8'h00, 8'hFF, 3'd0, 3'd0, 1'b0, 1'b0);
    add_req(REQ_RAW,  8'h09, 8'hFF, 3'd0, 3'd0, 1'b0, 1'b0);
    add_req(REQ_RAW,  8'hFF, 8'h00, 3'd7, 3'd7, 1'b1, 1'b0);
    add_req(REQ_RAW,  8'h01, 8'hFF, 3'd0, 3'd0, 1'b0, 1'b0);
    add_req(REQ_RAW,  8'h08, 8'hA5, 3'd0, 3'd0, 1'b0, 1'b0);
    add_req(REQ_PIXR, 8'h00, 8'h00, 3'd0, 3'd0, 1'b0, 1'b0);
    add_req(REQ_PIXW, 8'h00, 8'h00, 3'd0, 3'd0, 1'b0, 1'b0);
    add_req(REQ_PIXR, 8'h00, 8'h00, 3'd0, 3'd0, 1'b0, 1'b0);
    add_req(REQ_PIXW, 8'hFF, 8'hFF, 3'd7, 3'd7, 1'b1, 1'b0);
    add_req(REQ_PIXR, 8'h00, 8'h00, 3'd7, 3'd7, 1'b0, 1'b0);
    add_req(REQ_PIXW, 8'h00, 8'h00, 3'd3, 3'd1, 1'b1, 1'b0);
    add_req(REQ_PIXR, 8'h00, 8'h00, 3'd3, 3'd1, 1'b0, 1'b0);
    add_req(REQ_PIXW, 8'h00, 8'h00, 3'd3, 3'd1, 1'b0, 1'b0);
    add_req(REQ_PIXR, 8'h00, 8'h00, 3'd3, 3'd1, 1'b0, 1'b0);
    add_req(REQ_PAT,  8'h00, 8'h01, 3'd2, 3'd0, 1'b0, 1'b0);
    add_req(REQ_PAT,  8'h00, 8'h80, 3'd5, 3'd0, 1'b0, 1'b0);
    add_req(REQ_PAT,  8'h00, 8'hFF, 3'd6, 3'd0, 1'b0, 1'b0);
    add_req(REQ_PAT,  8'h00, 8'h00, 3'd1, 3'd0, 1'b0, 1'b0);
    add_req(REQ_PIXR, 8'h00, 8'h00, 3'd2, 3'd0, 1'b0, 1'b0);
    add_req(REQ_RAW,  8'h04, 8'h00, 3'd0, 3'd0, 1'b0, 1'b1);
    add_req(REQ_PIXW, 8'h00, 8'h00, 3'd4, 3'd4, 1'b1, 1'b0);
    add_req(REQ_PIXR, 8'h00, 8'h00, 3'd4, 3'd4, 1'b0, 1'b0);
    add_req(REQ_RAW,  8'h0F, 8'h00, 3'd0, 3'd0, 1'b0, 1'b0);

    for (int i = 0; i < RAND_REQS; i++) begin
      pick = $urandom_range(0, 99);
      addr = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) addr = 8'($urandom_range(1, 8));
      else if ($urandom_range(0, 9) == 0) addr = 8'd0;
      add_req((pick < 25) ? REQ_RAW : (pick < 55) ? REQ_PIXW :
              (pick < 80) ? REQ_PIXR : REQ_PAT,
              addr, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
              3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), (i % 100) == 50);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pend_q.size() != 0 || link_bit_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d raw, %0d pixel write, %0d pixel read, %0d pattern requests;",
             kind_cnt[REQ_RAW], kind_cnt[REQ_PIXW], kind_cnt[REQ_PIXR], kind_cnt[REQ_PAT]);
    $display("checked %0d link results, %0d reads found a lit pixel.",
             bits_checked, lit_reads);
    if (err_cnt == 0) begin
      $display("led_matrix_shadow_serializer_tb: done, clean");
    end else begin
      $display("led_matrix_shadow_serializer_tb: done, errors");
    end
    $finish;
  end

endmodule
